// ===== rtl/core/dbrd_pkg.sv =====
package dbrd_pkg;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_KIND      = 4'd1,
        PH_ROWS_PFX  = 4'd2,
        PH_ROWS_BODY = 4'd3,
        PH_ID_PFX    = 4'd4,
        PH_ID_BODY   = 4'd5,
        PH_STATUS    = 4'd6,
        PH_WARN      = 4'd7,
        PH_CODE      = 4'd8,
        PH_MARK      = 4'd9,
        PH_STATE     = 4'd10,
        PH_DONE      = 4'd11
    } phase_t;

    localparam logic [1:0] KIND_OK    = 2'd0;
    localparam logic [1:0] KIND_ERR   = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    localparam logic [7:0] BYTE_OK    = 8'h00;
    localparam logic [7:0] BYTE_LE2   = 8'hFC;
    localparam logic [7:0] BYTE_LE3   = 8'hFD;
    localparam logic [7:0] BYTE_LE8   = 8'hFE;
    localparam logic [7:0] BYTE_NULL  = 8'hFB;
    localparam logic [7:0] BYTE_ERR   = 8'hFF;
    localparam logic [7:0] BYTE_MARK  = 8'h23;

    localparam int OUT_W = 256;

    // One classified byte handed from the framer to the decoder.
    typedef struct packed {
        logic [7:0]  data;
        logic        first;     // first payload byte
        logic        last;      // last payload byte, or header of empty packet
        logic        empty;     // header of an empty packet, data unused
        logic        p41;
        logic [7:0]  seq;
        logic [23:0] len;
    } fe_item_t;

endpackage

// ===== rtl/core/db_response_deframer_decoder.sv =====
// Response deframer and OK/ERR decoder.
// Slave stream: one server stream byte per request on s_axis_tdata.
// Master stream: one 256-bit summary per packet on m_axis_tdata, raised after
// the last payload byte, or after the sequence byte of an empty packet.
// Register sqlstate_en (address 0, reset 1) is written over the APB port;
// it is sampled when the second error code byte passes the front end.
// Throughput is one byte per cycle while s_axis_tready is high. The framer
// tracks the header and payload count, a two-entry queue follows, and the
// decoder updates its field accumulators and fills the output register.
// m_axis_tvalid is registered and rises once the decoder takes the final byte of a packet from the queue.
// Reset clears framing, decoder state and the output valid flag; sqlstate_en
// returns to 1. When the receiver stalls, the output register holds its
// summary, the queue fills and s_axis_tready falls after two more payload
// bytes; nothing is dropped.
module db_response_deframer_decoder
    import dbrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // stream_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sequence_id, payload_length, packet_kind, parse_failed, row_count,
    // insert_key, server_status, warn_total, error_code, sql_state
    output logic [255:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic p41_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {31'd0, p41_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p41_reg <= 1'b1;
        else if (psel && penable && pwrite && paddr == 1'b0)
            p41_reg <= pwdata[0];
    end

    logic     f_valid, f_ready, d_valid, d_ready;
    fe_item_t f_item, d_item;

    dbrd_framer u_framer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .p41      (p41_reg),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_item   (f_item)
    );

    dbrd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_item  (d_item)
    );

    dbrd_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (d_valid),
        .q_ready   (d_ready),
        .q_item    (d_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/core/dbrd_framer.sv =====
module dbrd_framer
    import dbrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    input  logic       p41,
    output logic       q_valid,
    input  logic       q_ready,
    output fe_item_t   q_item
);

    logic [1:0]  hidx_reg;
    logic [23:0] len_reg;
    logic [7:0]  seq_reg;
    logic [23:0] left_reg;
    logic        inpay_reg;
    logic        first_reg;

    assign in_ready = q_ready;
    logic fire;
    assign fire = in_valid && q_ready;

    always_comb
    begin
        q_item       = '0;
        q_item.data  = in_data;
        q_item.p41   = p41;
        q_item.first = first_reg;
        q_item.seq   = inpay_reg ? seq_reg : in_data;
        q_item.len   = len_reg;
        q_valid      = 1'b0;
        if (inpay_reg)
        begin
            q_valid     = in_valid;
            q_item.last = (left_reg == 24'd1);
        end
        else if (hidx_reg == 2'd3 && len_reg == 24'd0)
        begin
            q_valid      = in_valid;
            q_item.last  = 1'b1;
            q_item.empty = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hidx_reg  <= '0;
            len_reg   <= '0;
            seq_reg   <= '0;
            left_reg  <= '0;
            inpay_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (!inpay_reg)
            begin
                if (hidx_reg != 2'd3)
                begin
                    len_reg[8*hidx_reg +: 8] <= in_data;
                    hidx_reg <= hidx_reg + 2'd1;
                end
                else
                begin
                    hidx_reg <= '0;
                    seq_reg  <= in_data;
                    left_reg <= len_reg;
                    if (len_reg == 24'd0)
                        len_reg <= '0;
                    else
                    begin
                        inpay_reg <= 1'b1;
                        first_reg <= 1'b1;
                    end
                end
            end
            else
            begin
                first_reg <= 1'b0;
                left_reg  <= left_reg - 24'd1;
                if (left_reg == 24'd1)
                begin
                    inpay_reg <= 1'b0;
                    len_reg   <= '0;
                end
            end
        end
    end

endmodule

// ===== rtl/core/dbrd_fifo.sv =====
module dbrd_fifo
    import dbrd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  fe_item_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output fe_item_t out_item
);

    fe_item_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];

    logic wr, rd;
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

// ===== rtl/core/dbrd_decoder.sv =====
module dbrd_decoder
    import dbrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  fe_item_t         q_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    phase_t      ph_reg, ph_next;
    logic [3:0]  fbi_reg, fbi_next;
    logic [3:0]  lsz_reg, lsz_next;
    logic [63:0] rows_reg, rows_next, iid_reg, iid_next;
    logic [15:0] stat_reg, stat_next, warn_reg, warn_next, code_reg, code_next;
    logic [39:0] st_reg, st_next;
    logic [1:0]  kind_reg, kind_next;
    logic        fail_reg, fail_next;
    logic        ov_reg;
    logic [OUT_W-1:0] od_reg;

    logic [7:0] b;
    logic       fire, emit;
    logic       failed, okv, errv;
    logic [OUT_W-1:0] res;

    assign b         = q_item.data;
    assign q_ready   = !ov_reg || out_ready;
    assign fire      = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        ph_next   = ph_reg;
        fbi_next  = fbi_reg;
        lsz_next  = lsz_reg;
        rows_next = rows_reg;
        iid_next  = iid_reg;
        stat_next = stat_reg;
        warn_next = warn_reg;
        code_next = code_reg;
        st_next   = st_reg;
        kind_next = kind_reg;
        fail_next = fail_reg;
        if (q_item.first)
        begin
            if (b == BYTE_OK)
            begin
                kind_next = KIND_OK;
                ph_next   = PH_ROWS_PFX;
            end
            else if (b == BYTE_ERR)
            begin
                kind_next = KIND_ERR;
                ph_next   = PH_CODE;
            end
            else
            begin
                kind_next = KIND_OTHER;
                ph_next   = PH_DONE;
            end
            fbi_next = '0;
        end
        else if (!q_item.empty)
        begin
            unique case (ph_reg)
                PH_ROWS_PFX, PH_ID_PFX:
                begin
                    fbi_next = '0;
                    if (b < BYTE_NULL)
                    begin
                        if (ph_reg == PH_ROWS_PFX) rows_next = {56'd0, b};
                        else iid_next = {56'd0, b};
                        ph_next = (ph_reg == PH_ROWS_PFX) ? PH_ID_PFX : PH_STATUS;
                    end
                    else if (b == BYTE_LE2 || b == BYTE_LE3 || b == BYTE_LE8)
                    begin
                        lsz_next = (b == BYTE_LE2) ? 4'd2 : (b == BYTE_LE3) ? 4'd3 : 4'd8;
                        if (ph_reg == PH_ROWS_PFX) rows_next = '0;
                        else iid_next = '0;
                        ph_next = (ph_reg == PH_ROWS_PFX) ? PH_ROWS_BODY : PH_ID_BODY;
                    end
                    else
                    begin
                        fail_next = 1'b1;
                        ph_next   = PH_DONE;
                    end
                end
                PH_ROWS_BODY, PH_ID_BODY:
                begin
                    if (ph_reg == PH_ROWS_BODY)
                        rows_next = rows_reg | ({56'd0, b} << {fbi_reg[2:0], 3'b000});
                    else
                        iid_next = iid_reg | ({56'd0, b} << {fbi_reg[2:0], 3'b000});
                    fbi_next = fbi_reg + 4'd1;
                    if (fbi_next >= lsz_reg)
                    begin
                        fbi_next = '0;
                        ph_next  = (ph_reg == PH_ROWS_BODY) ? PH_ID_PFX : PH_STATUS;
                    end
                end
                PH_STATUS, PH_WARN, PH_CODE:
                begin
                    if (ph_reg == PH_STATUS)
                        stat_next[8*fbi_reg[0] +: 8] = stat_reg[8*fbi_reg[0] +: 8] | b;
                    else if (ph_reg == PH_WARN)
                        warn_next[8*fbi_reg[0] +: 8] = warn_reg[8*fbi_reg[0] +: 8] | b;
                    else
                        code_next[8*fbi_reg[0] +: 8] = code_reg[8*fbi_reg[0] +: 8] | b;
                    fbi_next = fbi_reg + 4'd1;
                    if (fbi_next >= 4'd2)
                    begin
                        fbi_next = '0;
                        if (ph_reg == PH_STATUS) ph_next = PH_WARN;
                        else if (ph_reg == PH_WARN) ph_next = PH_DONE;
                        else ph_next = q_item.p41 ? PH_MARK : PH_DONE;
                    end
                end
                PH_MARK:
                begin
                    fbi_next = '0;
                    if (b != BYTE_MARK)
                    begin
                        fail_next = 1'b1;
                        ph_next   = PH_DONE;
                    end
                    else
                        ph_next = PH_STATE;
                end
                PH_STATE:
                begin
                    if (fbi_reg < 4'd5)
                        st_next[8*fbi_reg[2:0] +: 8] = st_reg[8*fbi_reg[2:0] +: 8] | b;
                    fbi_next = fbi_reg + 4'd1;
                    if (fbi_next >= 4'd5)
                    begin
                        fbi_next = '0;
                        ph_next  = PH_DONE;
                    end
                end
                default:
                begin
                    fbi_next = '0;
                    ph_next  = PH_DONE;
                end
            endcase
        end
    end

    // Result is formed from the state after this byte is applied.
    always_comb
    begin
        failed = fail_next || (kind_next != KIND_OTHER && ph_next != PH_DONE);
        okv    = !failed && kind_next == KIND_OK;
        errv   = !failed && kind_next == KIND_ERR;
        res    = '0;
        res[7:0]     = q_item.seq;
        res[31:8]    = q_item.len;
        res[33:32]   = kind_next;
        res[34]      = failed;
        res[98:35]   = okv ? rows_next : 64'd0;
        res[162:99]  = okv ? iid_next : 64'd0;
        res[178:163] = okv ? stat_next : 16'd0;
        res[194:179] = okv ? warn_next : 16'd0;
        res[210:195] = errv ? code_next : 16'd0;
        res[250:211] = errv ? st_next : 40'd0;
    end

    assign emit = fire && q_item.last;

    always_ff @(posedge clk)
    begin
        if (emit)
            od_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            ph_reg   <= PH_HEADER;
            fbi_reg  <= '0;
            lsz_reg  <= '0;
            rows_reg <= '0;
            iid_reg  <= '0;
            stat_reg <= '0;
            warn_reg <= '0;
            code_reg <= '0;
            st_reg   <= '0;
            kind_reg <= KIND_OTHER;
            fail_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (fire)
            begin
                if (q_item.last)
                begin
                    ph_reg   <= PH_HEADER;
                    fbi_reg  <= '0;
                    lsz_reg  <= '0;
                    rows_reg <= '0;
                    iid_reg  <= '0;
                    stat_reg <= '0;
                    warn_reg <= '0;
                    code_reg <= '0;
                    st_reg   <= '0;
                    kind_reg <= KIND_OTHER;
                    fail_reg <= 1'b0;
                end
                else
                begin
                    ph_reg   <= ph_next;
                    fbi_reg  <= fbi_next;
                    lsz_reg  <= lsz_next;
                    rows_reg <= rows_next;
                    iid_reg  <= iid_next;
                    stat_reg <= stat_next;
                    warn_reg <= warn_next;
                    code_reg <= code_next;
                    st_reg   <= st_next;
                    kind_reg <= kind_next;
                    fail_reg <= fail_next;
                end
            end
        end
    end

endmodule

// ===== verif/db_response_checker.sv =====
`timescale 1ns / 100ps

module db_response_checker
    import dbrd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [255:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending
);

    typedef struct {
        logic [7:0]  seq;
        logic [23:0] len;
        logic [1:0]  kind;
        logic        failed;
        logic [63:0] rows;
        logic [63:0] insert_id;
        logic [15:0] status;
        logic [15:0] warnings;
        logic [15:0] code;
        logic [39:0] sql_state;
    } summary_t;

    summary_t summary_q[$];

    // Shadow of the decoder state.
    logic        p41;
    logic [1:0]  hdr_idx;
    logic [23:0] len_acc;
    logic [7:0]  seq_acc;
    logic [23:0] remaining;
    phase_t      phase;
    logic [3:0]  fidx;
    logic [3:0]  lsize;
    logic [63:0] rows_acc;
    logic [63:0] id_acc;
    logic [15:0] status_acc;
    logic [15:0] warn_acc;
    logic [15:0] code_acc;
    logic [39:0] state_acc;
    logic [1:0]  kind_acc;
    logic        fail_acc;

    assign pending = summary_q.size();

    task automatic clear_packet();
        hdr_idx    = '0;
        len_acc    = '0;
        seq_acc    = '0;
        remaining  = '0;
        fidx       = '0;
        lsize      = '0;
        rows_acc   = '0;
        id_acc     = '0;
        status_acc = '0;
        warn_acc   = '0;
        code_acc   = '0;
        state_acc  = '0;
        kind_acc   = KIND_OTHER;
        fail_acc   = 1'b0;
        phase      = PH_HEADER;
    endtask

    task automatic go(input phase_t ph);
        phase = ph;
        fidx  = '0;
    endtask

    function automatic logic [3:0] body_size(input logic [7:0] b);
        return (b == BYTE_LE2) ? 4'd2 : (b == BYTE_LE3) ? 4'd3 : 4'd8;
    endfunction

    task automatic push_summary();
        summary_t s;
        logic     bad;
        logic     ok_ok;
        logic     err_ok;
        bad    = fail_acc || (kind_acc != KIND_OTHER && phase != PH_DONE);
        ok_ok  = !bad && kind_acc == KIND_OK;
        err_ok = !bad && kind_acc == KIND_ERR;
        s.seq       = seq_acc;
        s.len       = len_acc;
        s.kind      = kind_acc;
        s.failed    = bad;
        s.rows      = ok_ok ? rows_acc : '0;
        s.insert_id = ok_ok ? id_acc : '0;
        s.status    = ok_ok ? status_acc : '0;
        s.warnings  = ok_ok ? warn_acc : '0;
        s.code      = err_ok ? code_acc : '0;
        s.sql_state = err_ok ? state_acc : '0;
        summary_q.push_back(s);
        clear_packet();
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        if (phase == PH_HEADER)
        begin
            if (hdr_idx < 2'd3)
            begin
                len_acc = len_acc | (24'(b) << (8 * hdr_idx));
                hdr_idx++;
            end
            else
            begin
                seq_acc   = b;
                hdr_idx   = '0;
                remaining = len_acc;
                if (remaining == 0)
                    push_summary();
                else
                    go(PH_KIND);
            end
            return;
        end
        case (phase)
            PH_KIND:
                if (b == BYTE_OK)
                begin
                    kind_acc = KIND_OK;
                    go(PH_ROWS_PFX);
                end
                else if (b == BYTE_ERR)
                begin
                    kind_acc = KIND_ERR;
                    go(PH_CODE);
                end
                else
                begin
                    kind_acc = KIND_OTHER;
                    go(PH_DONE);
                end
            PH_ROWS_PFX:
                if (b < BYTE_NULL)
                begin
                    rows_acc = 64'(b);
                    go(PH_ID_PFX);
                end
                else if (b == BYTE_NULL || b == BYTE_ERR)
                begin
                    fail_acc = 1'b1;
                    go(PH_DONE);
                end
                else
                begin
                    lsize    = body_size(b);
                    rows_acc = '0;
                    go(PH_ROWS_BODY);
                end
            PH_ROWS_BODY:
            begin
                rows_acc = rows_acc | (64'(b) << (8 * fidx[2:0]));
                fidx++;
                if (fidx >= lsize)
                    go(PH_ID_PFX);
            end
            PH_ID_PFX:
                if (b < BYTE_NULL)
                begin
                    id_acc = 64'(b);
                    go(PH_STATUS);
                end
                else if (b == BYTE_NULL || b == BYTE_ERR)
                begin
                    fail_acc = 1'b1;
                    go(PH_DONE);
                end
                else
                begin
                    lsize  = body_size(b);
                    id_acc = '0;
                    go(PH_ID_BODY);
                end
            PH_ID_BODY:
            begin
                id_acc = id_acc | (64'(b) << (8 * fidx[2:0]));
                fidx++;
                if (fidx >= lsize)
                    go(PH_STATUS);
            end
            PH_STATUS:
            begin
                status_acc = status_acc | (16'(b) << (8 * fidx[0]));
                fidx++;
                if (fidx >= 2)
                    go(PH_WARN);
            end
            PH_WARN:
            begin
                warn_acc = warn_acc | (16'(b) << (8 * fidx[0]));
                fidx++;
                if (fidx >= 2)
                    go(PH_DONE);
            end
            PH_CODE:
            begin
                code_acc = code_acc | (16'(b) << (8 * fidx[0]));
                fidx++;
                if (fidx >= 2)
                    go(p41 ? PH_MARK : PH_DONE);
            end
            PH_MARK:
                if (b != BYTE_MARK)
                begin
                    fail_acc = 1'b1;
                    go(PH_DONE);
                end
                else
                begin
                    go(PH_STATE);
                end
            PH_STATE:
            begin
                state_acc = state_acc | (40'(b) << (8 * (fidx % 5)));
                fidx++;
                if (fidx >= 5)
                    go(PH_DONE);
            end
            default:
                go(PH_DONE);
        endcase
        remaining = remaining - 24'd1;
        if (remaining == 0)
            push_summary();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    task automatic check_summary(input logic [255:0] d);
        summary_t e;
        if (summary_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected summary %h", d);
            return;
        end
        e = summary_q.pop_front();
        check_field("sequence_id",    64'(e.seq),       64'(d[7:0]));
        check_field("payload_length", 64'(e.len),       64'(d[31:8]));
        check_field("packet_kind",    64'(e.kind),      64'(d[33:32]));
        check_field("parse_failed",   64'(e.failed),    64'(d[34]));
        check_field("row_count",      e.rows,           d[98:35]);
        check_field("insert_key",     e.insert_id,      d[162:99]);
        check_field("server_status",  64'(e.status),    64'(d[178:163]));
        check_field("warn_total",     64'(e.warnings),  64'(d[194:179]));
        check_field("error_code",     64'(e.code),      64'(d[210:195]));
        check_field("sql_state",      64'(e.sql_state), 64'(d[250:211]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p41 = 1'b1;
            clear_packet();
            summary_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == 1'b0)
                p41 = pwdata[0];
            // Outputs are checked first so a summary never meets its own request.
            if (m_axis_tvalid && m_axis_tready)
                check_summary(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                absorb_byte(s_axis_tdata);
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb
    import dbrd_pkg::*;
();

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [255:0] m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [0:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int  fail_count;
    int  pending;
    int  bytes_sent;
    int  quiet_cycles;
    bit  quiet;
    bit  hold_off;
    logic [7:0] body_q[$];

    always #5 clk = ~clk;

    db_response_deframer_decoder u_top (.*);

    db_response_checker u_chk (.*);

    // Watchdog: cycles without any request moving on either stream.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("[db_response_deframer_decoder] ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none near the end.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 9);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                n = quiet ? 1 : $urandom_range(1, 30);
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int n;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        bytes_sent++;
    endtask

    // Frames the collected payload; drop shortens the declared length.
    task automatic send_packet(input int drop);
        int len;
        int n;
        len = body_q.size() - drop;
        if (len < 0)
            len = 0;
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(len[23:16]);
        send_byte(8'($urandom));
        for (n = 0; n < len; n++)
            send_byte(body_q[n]);
        body_q.delete();
    endtask

    task automatic add_lenenc(input int form);
        logic [63:0] v;
        int          i;
        v = {$urandom, $urandom};
        case (form)
            0: body_q.push_back(8'($urandom_range(0, 250)));
            1:
            begin
                body_q.push_back(BYTE_LE2);
                for (i = 0; i < 2; i++) body_q.push_back(v[8*i +: 8]);
            end
            2:
            begin
                body_q.push_back(BYTE_LE3);
                for (i = 0; i < 3; i++) body_q.push_back(v[8*i +: 8]);
            end
            3:
            begin
                body_q.push_back(BYTE_LE8);
                for (i = 0; i < 8; i++) body_q.push_back(v[8*i +: 8]);
            end
            4: body_q.push_back(BYTE_NULL);
            default: body_q.push_back(BYTE_ERR);
        endcase
    endtask

    task automatic build_ok(input int f1, input int f2);
        int i;
        body_q.push_back(BYTE_OK);
        add_lenenc(f1);
        add_lenenc(f2);
        for (i = 0; i < 4; i++)
            body_q.push_back(8'($urandom));
    endtask

    task automatic build_err(input bit good_mark);
        int i;
        body_q.push_back(BYTE_ERR);
        body_q.push_back(8'($urandom));
        body_q.push_back(8'($urandom));
        body_q.push_back(good_mark ? BYTE_MARK : 8'($urandom_range(0, 34)));
        for (i = 0; i < 5; i++)
            body_q.push_back(8'($urandom));
    endtask

    task automatic add_trailer(input int n);
        repeat (n) body_q.push_back(8'($urandom));
    endtask

    task automatic write_p41(input logic v);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 1'b0;
        pwdata  <= {$urandom} & 32'hFFFF_FFFE | 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Lets the pipeline drain before touching the register.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic random_packet();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            build_ok($urandom_range(0, 3) == 0 ? $urandom_range(0, 5) : 0,
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 5) : 0);
        else if (pick < 70)
            build_err($urandom_range(0, 5) != 0);
        else if (pick < 80)
            body_q.push_back(8'($urandom_range(1, 254)));
        else if (pick < 85)
            ;
        else
            add_trailer($urandom_range(1, 6));
        if (pick < 70 && $urandom_range(0, 2) == 0)
            add_trailer($urandom_range(1, 3));
        send_packet($urandom_range(0, 6) == 0 ? $urandom_range(1, body_q.size() + 1) : 0);
    endtask

    initial
    begin
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        send_packet(0);                 // empty packet
        build_ok(0, 0); send_packet(0);
        build_ok(1, 2); send_packet(0);
        build_ok(3, 3); send_packet(0);
        build_ok(4, 0); add_trailer(2); send_packet(0);
        build_ok(0, 5); send_packet(0);
        build_ok(3, 0); send_packet(4);  // truncated OK
        build_err(1'b1); send_packet(0);
        build_err(1'b0); send_packet(0);
        build_err(1'b1); send_packet(3); // truncated SQL state
        body_q.push_back(8'h7E); add_trailer(3); send_packet(0);
        body_q.push_back(BYTE_OK); add_trailer(299); send_packet(0);
        drain();
        write_p41(1'b0);
        build_err(1'b1); send_packet(0);
        build_err(1'b0); send_packet(0);
        build_err(1'b0); send_packet(8);
        drain();
        write_p41(1'b1);

        // Long receiver hold-off while the sender keeps streaming.
        hold_off = 1'b1;
        for (k = 0; k < 6; k++)
            random_packet();

        // Random part in phases with the register rewritten at random between them.
        k = 0;
        while (bytes_sent < 1000)
        begin
            if (bytes_sent > 850)
                quiet = 1'b1;
            random_packet();
            if (++k % 25 == 0)
            begin
                drain();
                write_p41(1'($urandom));
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[db_response_deframer_decoder] OK");
        else
            $display("[db_response_deframer_decoder] ERROR");
        $finish;
    end

endmodule
